[rtl/bis_pkg.sv]
// ----------------------------------------------------------------------------
// bis_pkg
// Shared types, register indexes, state codes and helpers for the bank
// interleave request splitter.
// ----------------------------------------------------------------------------
package bis_pkg;

    localparam int MaxReqBytes = 64;
    localparam int MapSlots    = 16;

    localparam int AddrW  = 64;
    localparam int SizeW  = 7;
    localparam int PortW  = 4;
    localparam int PaddrW = 6;
    localparam int PdataW = 64;

    // register indexes
    localparam logic [2:0] REG_INTERLEAVE = 3'd0;
    localparam logic [2:0] REG_STAGE      = 3'd1;
    localparam logic [2:0] REG_SHIFT      = 3'd2;
    localparam logic [2:0] REG_BASE       = 3'd3;
    localparam logic [2:0] REG_XMODE      = 3'd4;
    localparam logic [2:0] REG_MAP_EN     = 3'd5;
    localparam logic [2:0] REG_MAP_TABLE  = 3'd6;
    localparam logic [2:0] REG_OUT_COUNT  = 3'd7;

    // translation modes
    localparam logic [1:0] XMODE_NONE   = 2'd0;
    localparam logic [1:0] XMODE_SHIFT  = 2'd1;
    localparam logic [1:0] XMODE_OFFSET = 2'd2;

    // sequencer states
    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SUB   = 2'd1;
    localparam logic [1:0] ST_SLICE = 2'd2;

    typedef struct packed {
        logic [3:0]       interleave_bits;
        logic [3:0]       slot_bits;
        logic [5:0]       shift_amount;
        logic [AddrW-1:0] base_offset;
        logic [1:0]       translate_mode;
        logic             map_enable;
        logic [63:0]      map_table;
        logic [4:0]       output_count;
    } t_cfg;

    function automatic logic [AddrW-1:0] low_mask(input logic [5:0] n);
        low_mask = ~({AddrW{1'b1}} << n);
    endfunction

endpackage

[rtl/bank_interleave_request_splitter.sv]
// ----------------------------------------------------------------------------
// bank_interleave_request_splitter
// Splits a request into interleave-aligned slices, picks a port per slice.
// ----------------------------------------------------------------------------
// A request is accepted in the idle state; in the offset state the shared
// 64-bit adder removes the base offset, then in the slice state the same
// adder advances the address once per slice. A slice waits while the output
// register is still held by the sink. Zero-size requests give no item.
// Registers sit at byte address 8*index.
module bank_interleave_request_splitter (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // APB configuration
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [bis_pkg::PaddrW-1:0] paddr,
    input  logic [bis_pkg::PdataW-1:0] pwdata,
    output logic [bis_pkg::PdataW-1:0] prdata,
    output logic                       pready,
    // request stream
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [71:0]                s_axis_tdata,  // req_address[63:0], req_size[70:64]
    // slice stream
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    output logic [79:0]                m_axis_tdata,  // out_port[3:0], slice_address[67:4],
                                                      // slice_size[74:68]
    output logic                       m_axis_tlast,  // last_slice
    output logic                       m_axis_tuser   // bad_port
);
    import bis_pkg::*;

    t_cfg             r_cfg;
    logic [2:0]       w_idx;
    logic             w_wr;

    logic [1:0]       r_state;
    logic [1:0]       n_state;
    logic [AddrW-1:0] r_addr;
    logic [SizeW-1:0] r_rem;

    logic [AddrW-1:0] w_sum;
    logic [AddrW-1:0] w_add_b;
    logic             w_sub;

    logic [15:0]      w_ps;
    logic [15:0]      w_raw;
    logic [SizeW-1:0] w_size;
    logic             w_ident;
    logic             w_load;
    logic             w_last;

    logic [PortW-1:0] w_port;
    logic             w_bad;
    logic [AddrW-1:0] w_xaddr;

    logic             r_out_valid;
    logic [PortW-1:0] r_out_port;
    logic [AddrW-1:0] r_out_addr;
    logic [SizeW-1:0] r_out_size;
    logic             r_out_last;
    logic             r_out_bad;

    logic [SizeW-1:0] w_req_size;

    // configuration
    assign pready = 1'b1;
    assign w_idx  = paddr[5:3];
    assign w_wr   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.interleave_bits <= 4'd2;
            r_cfg.slot_bits       <= 4'd4;
            r_cfg.shift_amount    <= '0;
            r_cfg.base_offset     <= '0;
            r_cfg.translate_mode  <= XMODE_NONE;
            r_cfg.map_enable      <= 1'b0;
            r_cfg.map_table       <= '0;
            r_cfg.output_count    <= 5'd16;
        end else if (w_wr) begin
            case (w_idx)
                REG_INTERLEAVE: r_cfg.interleave_bits <= pwdata[3:0];
                REG_STAGE:      r_cfg.slot_bits       <= pwdata[3:0];
                REG_SHIFT:      r_cfg.shift_amount    <= pwdata[5:0];
                REG_BASE:       r_cfg.base_offset     <= pwdata;
                REG_XMODE:      r_cfg.translate_mode  <= pwdata[1:0];
                REG_MAP_EN:     r_cfg.map_enable      <= pwdata[0];
                REG_MAP_TABLE:  r_cfg.map_table       <= pwdata;
                REG_OUT_COUNT:  r_cfg.output_count    <= pwdata[4:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_INTERLEAVE: prdata = {60'd0, r_cfg.interleave_bits};
            REG_STAGE:      prdata = {60'd0, r_cfg.slot_bits};
            REG_SHIFT:      prdata = {58'd0, r_cfg.shift_amount};
            REG_BASE:       prdata = r_cfg.base_offset;
            REG_XMODE:      prdata = {62'd0, r_cfg.translate_mode};
            REG_MAP_EN:     prdata = {63'd0, r_cfg.map_enable};
            REG_MAP_TABLE:  prdata = r_cfg.map_table;
            REG_OUT_COUNT:  prdata = {59'd0, r_cfg.output_count};
            default:        prdata = '0;
        endcase
    end

    // slice size
    assign w_ident = (r_cfg.interleave_bits == '0) && (r_cfg.slot_bits == '0);
    assign w_ps    = 16'd1 << r_cfg.interleave_bits;
    assign w_raw   = w_ps - (r_addr[15:0] & (w_ps - 16'd1));

    always_comb begin
        if (w_ident || (w_raw > {9'd0, r_rem})) begin
            w_size = r_rem;
        end else begin
            w_size = w_raw[SizeW-1:0];
        end
    end

    assign w_last = (w_size == r_rem);
    assign w_load = (r_state == ST_SLICE) && (!r_out_valid || m_axis_tready);

    // shared adder
    assign w_sub   = (r_state == ST_SUB);
    assign w_add_b = w_sub ? r_cfg.base_offset : {{(AddrW-SizeW){1'b0}}, w_size};

    bis_addsub u_addsub (
        .i_a   (r_addr),
        .i_b   (w_add_b),
        .i_sub (w_sub),
        .o_y   (w_sum)
    );

    bis_route u_route (
        .i_cfg   (r_cfg),
        .i_addr  (r_addr),
        .o_port  (w_port),
        .o_bad   (w_bad),
        .o_xaddr (w_xaddr)
    );

    // sequencer
    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_req_size    = (s_axis_tdata[70:64] > SizeW'(MaxReqBytes)) ?
                           SizeW'(MaxReqBytes) : s_axis_tdata[70:64];

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (s_axis_tvalid) n_state = ST_SUB;
            end
            ST_SUB: begin
                n_state = (r_rem == '0) ? ST_IDLE : ST_SLICE;
            end
            ST_SLICE: begin
                if (w_load && w_last) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_addr <= s_axis_tdata[63:0];
            r_rem  <= w_req_size;
        end else if (r_state == ST_SUB) begin
            r_addr <= w_sum;
        end else if (w_load) begin
            r_addr <= w_sum;
            r_rem  <= r_rem - w_size;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_port <= w_port;
            r_out_addr <= w_xaddr;
            r_out_size <= w_size;
            r_out_last <= w_last;
            r_out_bad  <= w_bad;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'd0, r_out_size, r_out_addr, r_out_port};
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tuser  = r_out_bad;

    // checks
    a_slice_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SLICE) |-> (r_rem != '0))
        else $error("slice state with nothing left");

    a_slice_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SLICE) |-> ((w_size != '0) && (w_size <= r_rem)))
        else $error("slice size out of range");

    a_accept_sub: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> (r_state == ST_SUB))
        else $error("accepted item not followed by offset removal");

    a_bad_port: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_bad) |-> (r_out_port == '0))
        else $error("flagged slice carries a port");

endmodule

[rtl/bis_addsub.sv]
// ----------------------------------------------------------------------------
// bis_addsub
// Shared 64-bit adder: base offset removal and per-slice address advance.
// ----------------------------------------------------------------------------
module bis_addsub (
    input  logic [bis_pkg::AddrW-1:0] i_a,
    input  logic [bis_pkg::AddrW-1:0] i_b,
    input  logic                      i_sub,
    output logic [bis_pkg::AddrW-1:0] o_y
);
    import bis_pkg::*;

    logic [AddrW-1:0] w_b;

    assign w_b = i_sub ? ~i_b : i_b;
    assign o_y = i_a + w_b + {{(AddrW-1){1'b0}}, i_sub};

endmodule

[rtl/bis_route.sv]
// ----------------------------------------------------------------------------
// bis_route
// Port selection and address translation for one slice address.
// ----------------------------------------------------------------------------
module bis_route (
    input  bis_pkg::t_cfg             i_cfg,
    input  logic [bis_pkg::AddrW-1:0] i_addr,
    output logic [bis_pkg::PortW-1:0] o_port,
    output logic                      o_bad,
    output logic [bis_pkg::AddrW-1:0] o_xaddr
);
    import bis_pkg::*;

    logic [5:0]       w_lb;
    logic [5:0]       w_sb;
    logic [5:0]       w_lsb;
    logic [AddrW-1:0] w_low;
    logic [AddrW-1:0] w_slot_full;
    logic [AddrW-1:0] w_slot_mask;
    logic [14:0]      w_slot;
    logic [PortW-1:0] w_p;
    logic             w_map_bad;

    assign w_lb  = {2'b00, i_cfg.interleave_bits};
    assign w_sb  = {2'b00, i_cfg.slot_bits};
    assign w_lsb = w_lb + w_sb;
    assign w_low = i_addr & low_mask(w_lb);

    assign w_slot_full = i_addr >> w_lb;
    assign w_slot_mask = low_mask(w_sb);
    assign w_slot      = w_slot_full[14:0] & w_slot_mask[14:0];

    always_comb begin
        w_map_bad = 1'b0;
        w_p       = w_slot[PortW-1:0];
        if (i_cfg.map_enable) begin
            if (w_slot >= 15'(MapSlots)) begin
                w_map_bad = 1'b1;
            end
            w_p = i_cfg.map_table[{w_slot[3:0], 2'b00} +: PortW];
        end else if (w_slot > 15'(4'hF)) begin
            w_map_bad = 1'b1;
        end
    end

    always_comb begin
        o_bad  = w_map_bad || ({1'b0, w_p} >= i_cfg.output_count);
        o_port = o_bad ? '0 : w_p;
    end

    always_comb begin
        case (i_cfg.translate_mode)
            XMODE_OFFSET: begin
                o_xaddr = ((i_addr & ~low_mask(w_lsb)) >> w_sb) | w_low;
            end
            XMODE_SHIFT: begin
                if (i_cfg.shift_amount != '0) begin
                    o_xaddr = ((i_addr >> i_cfg.shift_amount) & ~low_mask(w_lb)) | w_low;
                end else begin
                    o_xaddr = i_addr;
                end
            end
            default: begin
                o_xaddr = i_addr;
            end
        endcase
    end

endmodule

[tb/bis_slice_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bis_slice_checker
// Watches the register port and both streams of the request splitter. Keeps
// its own copy of the registers, cuts every accepted request into the slices
// it should produce and compares each emitted slice, field by field, with
// the oldest one still owed.
// ----------------------------------------------------------------------------
module bis_slice_checker (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_psel,
    input  logic                       i_penable,
    input  logic                       i_pwrite,
    input  logic                       i_pready,
    input  logic [bis_pkg::PaddrW-1:0] i_paddr,
    input  logic [bis_pkg::PdataW-1:0] i_pwdata,
    input  logic                       i_req_valid,
    input  logic                       i_req_ready,
    input  logic [71:0]                i_req_data,    // req_address, req_size
    input  logic                       i_slice_valid,
    input  logic                       i_slice_ready,
    input  logic [79:0]                i_slice_data,  // out_port, slice_address, slice_size
    input  logic                       i_slice_last,  // last_slice
    input  logic                       i_slice_user,  // bad_port
    output int                         o_pending,
    output int                         o_mismatches,
    output int                         o_slices_checked
);
    import bis_pkg::*;

    typedef struct packed {
        logic [PortW-1:0] port;
        logic [AddrW-1:0] addr;
        logic [SizeW-1:0] size;
        logic             last;
        logic             bad;
    } t_slice;

    t_cfg   regs;
    t_slice owed_slices[$];
    t_slice got;
    t_slice want;

    initial begin
        o_pending        = 0;
        o_mismatches     = 0;
        o_slices_checked = 0;
    end

    function automatic logic [63:0] span_mask(input int unsigned n);
        if (n >= 64) return '1;
        return (64'd1 << n) - 64'd1;
    endfunction

    function automatic logic [63:0] translated(input logic [63:0] a);
        int unsigned lb;
        int unsigned sb;
        logic [63:0] low;
        lb  = regs.interleave_bits;
        sb  = regs.slot_bits;
        low = a & span_mask(lb);
        if (regs.translate_mode == XMODE_OFFSET) return ((a & ~span_mask(lb + sb)) >> sb) + low;
        if (regs.translate_mode == XMODE_SHIFT && regs.shift_amount != 0)
            return ((a >> regs.shift_amount) & ~span_mask(lb)) | low;
        return a;
    endfunction

    // {bad, port}
    function automatic logic [4:0] port_choice(input logic [63:0] a);
        logic [63:0] slot;
        logic [63:0] p;
        slot = (a >> regs.interleave_bits) & span_mask(regs.slot_bits);
        if (regs.map_enable) begin
            if (slot >= MapSlots) return {1'b1, 4'd0};
            p = (regs.map_table >> {slot[3:0], 2'b00}) & 64'hf;
        end else begin
            p = slot;
        end
        if (p >= {59'd0, regs.output_count} || p > 64'd15) return {1'b1, 4'd0};
        return {1'b0, p[3:0]};
    endfunction

    function automatic void split_request(input logic [63:0] req_addr,
                                          input logic [6:0] req_size);
        logic [63:0] a;
        logic [63:0] chunk;
        logic [63:0] lead;
        logic [63:0] left;
        logic [63:0] sz;
        logic [4:0]  pick;
        t_slice      s;
        a    = req_addr - regs.base_offset;
        left = {57'd0, req_size};
        if (left > 64'(MaxReqBytes)) left = 64'(MaxReqBytes);
        if (left == 0) return;
        if (regs.interleave_bits == 0 && regs.slot_bits == 0) begin
            chunk = left;
            lead  = 0;
        end else begin
            chunk = 64'd1 << regs.interleave_bits;
            lead  = a & (chunk - 64'd1);
            if (lead != 0) lead = chunk - lead;
        end
        while (left != 0) begin
            sz   = (lead != 0) ? lead : chunk;
            lead = 0;
            if (sz > left) sz = left;
            pick   = port_choice(a);
            s.port = pick[3:0];
            s.bad  = pick[4];
            s.addr = translated(a);
            s.size = sz[6:0];
            s.last = (sz == left);
            owed_slices.insert(owed_slices.size(), s);
            left = left - sz;
            a    = a + sz;
        end
    endfunction

    task automatic report_mismatch(input string msg);
        o_mismatches++;
        if (o_mismatches <= 40) $display("[%0t] mismatch: %s", $time, msg);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            regs.interleave_bits = 4'd2;
            regs.slot_bits       = 4'd4;
            regs.shift_amount    = 6'd0;
            regs.base_offset     = '0;
            regs.translate_mode  = XMODE_NONE;
            regs.map_enable      = 1'b0;
            regs.map_table       = '0;
            regs.output_count    = 5'd16;
            owed_slices.delete();
        end else begin
            if (i_slice_valid && i_slice_ready) begin
                got.port = i_slice_data[3:0];
                got.addr = i_slice_data[67:4];
                got.size = i_slice_data[74:68];
                got.last = i_slice_last;
                got.bad  = i_slice_user;
                if (owed_slices.size() == 0) begin
                    report_mismatch($sformatf("slice addr %h with nothing owed", got.addr));
                end else begin
                    want = owed_slices.pop_front();
                    if (got.port !== want.port)
                        report_mismatch($sformatf("slice %0d out_port %0d, want %0d",
                                                  o_slices_checked, got.port, want.port));
                    if (got.addr !== want.addr)
                        report_mismatch($sformatf("slice %0d slice_address %h, want %h",
                                                  o_slices_checked, got.addr, want.addr));
                    if (got.size !== want.size)
                        report_mismatch($sformatf("slice %0d slice_size %0d, want %0d",
                                                  o_slices_checked, got.size, want.size));
                    if (got.last !== want.last)
                        report_mismatch($sformatf("slice %0d last_slice %b, want %b",
                                                  o_slices_checked, got.last, want.last));
                    if (got.bad !== want.bad)
                        report_mismatch($sformatf("slice %0d bad_port %b, want %b",
                                                  o_slices_checked, got.bad, want.bad));
                end
                o_slices_checked++;
            end
            if (i_req_valid && i_req_ready) split_request(i_req_data[63:0], i_req_data[70:64]);
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[5:3])
                    REG_INTERLEAVE: regs.interleave_bits = i_pwdata[3:0];
                    REG_STAGE:      regs.slot_bits       = i_pwdata[3:0];
                    REG_SHIFT:      regs.shift_amount    = i_pwdata[5:0];
                    REG_BASE:       regs.base_offset     = i_pwdata;
                    REG_XMODE:      regs.translate_mode  = i_pwdata[1:0];
                    REG_MAP_EN:     regs.map_enable      = i_pwdata[0];
                    REG_MAP_TABLE:  regs.map_table       = i_pwdata;
                    REG_OUT_COUNT:  regs.output_count    = i_pwdata[4:0];
                    default: ;
                endcase
            end
        end
        o_pending = owed_slices.size();
    end

endmodule

[tb/tb_bank_interleave_request_splitter.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bank_interleave_request_splitter
// Drives requests and register writes into the splitter with random gaps on
// both streams; a side checker predicts and compares every slice. Directed
// settings cover identity mode, byte slicing, off-map slots, ports beyond the
// output count and every translation mode, then random settings follow.
// ----------------------------------------------------------------------------
module tb_bank_interleave_request_splitter;
    import bis_pkg::*;

    localparam int CycleLimit = 400_000;

    logic              i_clk   = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              psel    = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite  = 1'b0;
    logic [PaddrW-1:0] paddr   = '0;
    logic [PdataW-1:0] pwdata  = '0;
    logic [PdataW-1:0] prdata;
    logic              pready;
    logic              req_valid = 1'b0;
    logic              req_ready;
    logic [71:0]       req_data  = '0;
    logic              slice_valid;
    logic              slice_ready = 1'b0;
    logic [79:0]       slice_data;
    logic              slice_last;
    logic              slice_user;

    int          pending_slices;
    int          mismatches;
    int          slices_checked;
    int          cycle_count    = 0;
    int          send_idle_pct  = 35;
    int          sink_idle_pct  = 35;
    int          requests_sent  = 0;
    int          settings_used  = 0;
    logic [63:0] cur_base       = '0;

    always #4 i_clk = ~i_clk;

    bank_interleave_request_splitter dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (req_valid),
        .s_axis_tready (req_ready),
        .s_axis_tdata  (req_data),
        .m_axis_tvalid (slice_valid),
        .m_axis_tready (slice_ready),
        .m_axis_tdata  (slice_data),
        .m_axis_tlast  (slice_last),
        .m_axis_tuser  (slice_user)
    );

    bis_slice_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_psel           (psel),
        .i_penable        (penable),
        .i_pwrite         (pwrite),
        .i_pready         (pready),
        .i_paddr          (paddr),
        .i_pwdata         (pwdata),
        .i_req_valid      (req_valid),
        .i_req_ready      (req_ready),
        .i_req_data       (req_data),
        .i_slice_valid    (slice_valid),
        .i_slice_ready    (slice_ready),
        .i_slice_data     (slice_data),
        .i_slice_last     (slice_last),
        .i_slice_user     (slice_user),
        .o_pending        (pending_slices),
        .o_mismatches     (mismatches),
        .o_slices_checked (slices_checked)
    );

    always @(negedge i_clk) begin
        slice_ready <= ($urandom_range(99, 0) >= sink_idle_pct);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CycleLimit) begin
            $display("timeout after %0d cycles, %0d slices owed", cycle_count, pending_slices);
            $display("FAIL bank_interleave_request_splitter");
            $finish;
        end
    end

    // called at a falling edge, returns at a falling edge
    task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic set_all(input logic [63:0] lb, input logic [63:0] sb, input logic [63:0] sh,
                           input logic [63:0] base, input logic [63:0] mode,
                           input logic [63:0] men, input logic [63:0] tab,
                           input logic [63:0] cnt);
        write_reg(REG_INTERLEAVE, lb);
        write_reg(REG_STAGE, sb);
        write_reg(REG_SHIFT, sh);
        write_reg(REG_BASE, base);
        write_reg(REG_XMODE, mode);
        write_reg(REG_MAP_EN, men);
        write_reg(REG_MAP_TABLE, tab);
        write_reg(REG_OUT_COUNT, cnt);
        cur_base = base;
        settings_used++;
    endtask

    task automatic push_request(input logic [63:0] addr, input logic [6:0] size);
        while ($urandom_range(99, 0) < send_idle_pct) begin
            req_valid <= 1'b0;
            @(negedge i_clk);
        end
        req_valid <= 1'b1;
        req_data  <= {1'b0, size, addr};
        do @(posedge i_clk); while (!req_ready);
        @(negedge i_clk);
        requests_sent++;
    endtask

    // hold off until every owed slice is out, then let the block settle
    task automatic drain;
        req_valid <= 1'b0;
        while (pending_slices != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic random_settings;
        logic [63:0] lb;
        logic [63:0] sb;
        logic [63:0] cnt;
        lb  = 64'(($urandom_range(99, 0) < 80) ? $urandom_range(5, 0) : $urandom_range(15, 0));
        sb  = 64'(($urandom_range(99, 0) < 80) ? $urandom_range(6, 0) : $urandom_range(15, 7));
        cnt = 64'(($urandom_range(99, 0) < 75) ? $urandom_range(16, 1) : $urandom_range(31, 0));
        set_all(lb, sb, 64'($urandom_range(63, 0)), {$urandom, $urandom},
                64'($urandom_range(3, 0)), 64'($urandom_range(1, 0)),
                {$urandom, $urandom}, cnt);
    endtask

    task automatic random_request;
        logic [63:0] addr;
        logic [6:0]  size;
        int          pick;
        pick = $urandom_range(99, 0);
        if (pick < 60)      addr = {$urandom, $urandom};
        else if (pick < 80) addr = cur_base + 64'($urandom_range(4095, 0));
        else if (pick < 90) addr = 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(127, 0));
        else                addr = 64'($urandom_range(255, 0));
        pick = $urandom_range(99, 0);
        if (pick < 50)      size = 7'($urandom_range(8, 1));
        else if (pick < 80) size = 7'($urandom_range(64, 1));
        else if (pick < 90) size = 7'd64;
        else if (pick < 95) size = 7'd0;
        else                size = 7'($urandom_range(127, 65));
        push_request(addr, size);
    endtask

    initial begin
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset settings: 4-byte slices, 16 direct ports
        push_request(64'h0, 7'd1);
        push_request(64'h0, 7'd64);
        push_request(64'h3, 7'd64);
        push_request(64'hFFFF_FFFF_FFFF_FFFF, 7'd127);
        push_request(64'h40, 7'd0);
        push_request(64'h1F, 7'd65);
        drain();

        // identity mode, shift mode with zero shift, address below base
        set_all(0, 0, 0, 64'h1000, XMODE_SHIFT, 0, 0, 16);
        push_request(64'h1003, 7'd64);
        push_request(64'h0, 7'd17);
        drain();

        // mapped ports, slots off the map, ports past the output count
        set_all(3, 6, 0, 64'h8000_0000_0000_0040, XMODE_OFFSET, 1,
                64'hFEDC_BA98_7654_3210, 5);
        push_request(cur_base + (64'd20 << 3) + 2, 7'd30);
        push_request(cur_base + (64'd1 << 3), 7'd64);
        push_request(cur_base + (64'd15 << 3) + 7, 7'd9);
        push_request(64'h0, 7'd64);
        drain();

        // slices wider than any request, full shift, no ports at all
        set_all(12, 8, 63, 0, XMODE_SHIFT, 0, 0, 0);
        push_request(64'hFFFF_FFFF_FFFF_FFF0, 7'd64);
        push_request(64'h1234_5678_9ABC_DEF0, 7'd9);
        drain();

        // register fields above their nominal range, unused mode
        set_all(15, 15, 5, 64'hFFFF_FFFF_FFFF_FFFF, 3, 0, 64'hFFFF_FFFF_FFFF_FFFF, 31);
        push_request(64'h5555_AAAA_5555_AAAA, 7'd64);
        push_request(64'h7FF8, 7'd16);
        drain();

        // single-byte slices through the map
        set_all(0, 1, 1, 0, XMODE_SHIFT, 1, 64'h0000_0000_0000_0010, 2);
        push_request(64'h5, 7'd64);
        push_request(64'hFFFF_FFFF_FFFF_FFFE, 7'd3);
        drain();

        for (int ph = 0; ph < 8; ph++) begin
            random_settings();
            send_idle_pct = (ph == 3) ? 0 : 35;
            sink_idle_pct = (ph == 3) ? 0 : 35;
            for (int n = 0; n < 50; n++) begin
                if (n == 25) drain();
                random_request();
            end
            drain();
        end
        send_idle_pct = 35;
        sink_idle_pct = 35;

        while (pending_slices != 0) @(negedge i_clk);
        repeat (16) @(negedge i_clk);

        $display("covered %0d requests under %0d register settings, %0d slices compared",
                 requests_sent, settings_used + 1, slices_checked);
        if (mismatches == 0 && pending_slices == 0) begin
            $display("PASS bank_interleave_request_splitter");
        end else begin
            $display("%0d mismatches, %0d slices owed", mismatches, pending_slices);
            $display("FAIL bank_interleave_request_splitter");
        end
        $finish;
    end

endmodule

[files.f]
rtl/bis_pkg.sv
rtl/bis_addsub.sv
rtl/bis_route.sv
rtl/bank_interleave_request_splitter.sv
tb/bis_slice_checker.sv
tb/tb_bank_interleave_request_splitter.sv
